FILE: rtl/indexed_sequence_store_core_macros.svh
// Assertion helpers used by the RTL of the sequence store.
`ifndef INDEXED_SEQUENCE_STORE_CORE_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define ISC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("sequence store check failed");
`define ISC_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("sequence store reset check failed");
`else
`define ISC_ASSERT(label, prop)
`define ISC_ASSERT_RST(label, prop)
`endif

`endif

FILE: rtl/isc_pkg.sv
`default_nettype none

package isc_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 7;
    localparam int CNT_OUT_W = 7;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    typedef enum logic [2:0] {
        OP_ADD_FRONT = 3'd0,
        OP_ADD_BACK  = 3'd1,
        OP_READ      = 3'd2,
        OP_INSERT    = 3'd3,
        OP_DELETE    = 3'd4
    } op_e_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2
    } act_t;

    typedef struct packed {
        act_t             act;
        logic [CMP_W-1:0] pos;
    } cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/isc_cell.sv
`default_nettype none

module isc_cell import isc_pkg::*; (
    input  wire logic              aclk,
    input  wire cell_cmd_t         cmd,
    input  wire logic [CMP_W-1:0]  cell_idx,
    input  wire logic [DATA_W-1:0] load_val,
    input  wire logic [DATA_W-1:0] left_val,
    input  wire logic [DATA_W-1:0] right_val,
    output logic      [DATA_W-1:0] val_out,
    output logic      [DATA_W-1:0] rd_out
);

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;

    always_comb begin
        val_next = val_reg;
        case (cmd.act)
            ACT_INSERT: begin
                if (cell_idx > cmd.pos) begin
                    val_next = left_val;
                end else if (cell_idx == cmd.pos) begin
                    val_next = load_val;
                end
            end
            ACT_DELETE: begin
                if (cell_idx >= cmd.pos) begin
                    val_next = right_val;
                end
            end
            default: val_next = val_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val_out = val_reg;
    assign rd_out  = (cell_idx == cmd.pos) ? val_reg : '0;

endmodule

`default_nettype wire

FILE: rtl/indexed_sequence_store_core.sv
// Channel | Port group                 | Payload, lowest bit first
// --------+----------------------------+------------------------------------------
// Request | s_tvalid s_tready s_tdata  | opcode[2:0] position[9:3] data_in[41:10]
// Result  | m_tvalid m_tready m_tdata  | data_out[31:0] status[33:32] count[40:34]
//
// Each request is first registered; then, once no pending result holds it,
// every cell of the chain shifts, loads or holds in parallel and the result is
// registered. The read value comes from an OR over the cell outputs.
// A pending result stalls execution of the next request, not its transfer.
// Reset clears the entry count and the handshake state; cell contents are
// not reset.
`default_nettype none

`include "indexed_sequence_store_core_macros.svh"

module indexed_sequence_store_core import isc_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // opcode, position, data_in, zero pad
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // data_out, status, count, zero pad
    output logic      [M_DATA_W-1:0] m_tdata
);

    logic                busy_reg;
    logic                busy_next;
    logic [2:0]          op_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [DATA_W-1:0]   out_data_reg;
    logic [DATA_W-1:0]   out_data_next;
    status_t             out_status_reg;
    status_t             out_status_next;
    logic [CNT_W-1:0]    out_count_reg;

    logic                exec;
    logic                s_xfer;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic                in_range;
    logic                full;
    cell_cmd_t           cmd;
    logic [DATA_W-1:0]   rd_data;

    logic [DATA_W-1:0]   cell_val [CAPACITY];
    logic [DATA_W-1:0]   cell_rd  [CAPACITY];

    assign s_tready = !busy_reg;
    assign s_xfer   = s_tvalid && s_tready;
    assign exec     = busy_reg && (!out_valid_reg || m_tready);

    assign pos_ext  = CMP_W'(pos_reg);
    assign cnt_ext  = CMP_W'(count_reg);
    assign in_range = pos_ext < cnt_ext;
    assign full     = count_reg == CNT_W'(CAPACITY);

    assign out_data_next = ((op_reg == OP_READ) && in_range) ? rd_data : '0;

    always_comb begin
        cmd.act         = ACT_NONE;
        cmd.pos         = pos_ext;
        count_next      = count_reg;
        out_status_next = ST_OK;
        case (op_reg)
            OP_ADD_FRONT: begin
                if (full) begin
                    out_status_next = ST_FULL;
                end else begin
                    cmd.act    = ACT_INSERT;
                    cmd.pos    = '0;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_ADD_BACK: begin
                if (full) begin
                    out_status_next = ST_FULL;
                end else begin
                    cmd.act    = ACT_INSERT;
                    cmd.pos    = cnt_ext;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_READ: begin
                if (!in_range) begin
                    out_status_next = ST_RANGE;
                end
            end
            OP_INSERT: begin
                if (!in_range) begin
                    out_status_next = ST_RANGE;
                end else if (full) begin
                    out_status_next = ST_FULL;
                end else begin
                    cmd.act    = ACT_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_DELETE: begin
                if (!in_range) begin
                    out_status_next = ST_RANGE;
                end else begin
                    cmd.act    = ACT_DELETE;
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
                out_status_next = ST_OK;
            end
        endcase
        if (!exec) begin
            cmd.act    = ACT_NONE;
            count_next = count_reg;
        end
    end

    always_comb begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_data = rd_data | cell_rd[i];
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_val;
        logic [DATA_W-1:0] right_val;
        if (i == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_left
            assign left_val = cell_val[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_val = cell_val[i];
        end else begin : g_right
            assign right_val = cell_val[i+1];
        end
        isc_cell u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .cell_idx  (CMP_W'(i)),
            .load_val  (data_reg),
            .left_val  (left_val),
            .right_val (right_val),
            .val_out   (cell_val[i]),
            .rd_out    (cell_rd[i])
        );
    end

    always_comb begin
        busy_next = busy_reg;
        if (exec) begin
            busy_next = 1'b0;
        end
        if (s_xfer) begin
            busy_next = 1'b1;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (exec) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg   <= s_tdata[2:0];
            pos_reg  <= s_tdata[9:3];
            data_reg <= s_tdata[41:10];
        end
        if (exec) begin
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        {(M_DATA_W - DATA_W - 2 - CNT_OUT_W){1'b0}},
        CNT_OUT_W'(out_count_reg),
        out_status_reg,
        out_data_reg
    };

    `ISC_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY))
    `ISC_ASSERT(a_accept_sets_busy, s_xfer |=> busy_reg)
    `ISC_ASSERT(a_full_status_count,
        (m_tvalid && out_status_reg == ST_FULL) |-> (count_reg == CNT_W'(CAPACITY)))
    `ISC_ASSERT(a_exec_loads_output, exec |=> m_tvalid)
    `ISC_ASSERT_RST(a_reset_idle, !aresetn |=> (!busy_reg && !m_tvalid))

endmodule

`default_nettype wire
